FILE: src/hlis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlis_pkg
// Shared constants for the hashed lookup-then-insert store.
// ----------------------------------------------------------------------------
package hlis_pkg;
   localparam int CapBits = 11;
   localparam logic [63:0] MixMulA = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MixMulB = 64'h94D049BB133111EB;
   localparam logic [63:0] GoldenMul = 64'h9E3779B97F4A7C15;
endpackage
`default_nettype wire

FILE: src/hashed_lookup_then_insert_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_lookup_then_insert_store
// Linear-probing hash table: look up (group, query), then insert (group, key).
// ----------------------------------------------------------------------------
// hashing: a salt multiply and two mixing multiplies for the query, two for the
//   key, all on the shared multiplier; then the read and check states of each
//   probe in both walks, until the result shows
// flow: the front takes a new item only once the last has gone to the queue;
//   long probe runs in the back stall the front once the two-entry queue fills
// reset: synchronous, capacity back to SLOTS; a clearing pass over all SLOTS
//   slots follows, during which full stays high
module hashed_lookup_then_insert_store
   import hlis_pkg::*;
#(
   parameter int SLOT_BITS  = 10,
   parameter int VALUE_BITS = 64,
   parameter int GROUP_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [GROUP_BITS-1:0] req_group,
   input  wire logic [63:0]           req_query_code,
   input  wire logic [63:0]           req_key_code,
   input  wire logic [VALUE_BITS-1:0] req_key_value,
   output logic                       empty,
   input  wire logic                  pop,
   output logic                       rsp_hit,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic                       rsp_claimed_new,
   output logic                       rsp_table_full,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CapBits-1:0]    csr_capacity
);
   localparam int Slots = 1 << SLOT_BITS;
   localparam int QW = GROUP_BITS + 128 + VALUE_BITS + 2 * SLOT_BITS;

   logic [CapBits-1:0]    cap_ff;
   logic [SLOT_BITS:0]    cap_eff;
   logic                  f_valid, f_ready, f_in_ready, clearing;
   logic [GROUP_BITS-1:0] f_group, b_group;
   logic [63:0]           f_q, f_k, b_q, b_k;
   logic [VALUE_BITS-1:0] f_v, b_v;
   logic [SLOT_BITS-1:0]  f_qs, f_ks, b_qs, b_ks;
   logic                  q_full, q_empty, b_pop;
   logic                  r_valid;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapBits'(Slots);
      else if (csr_valid) cap_ff <= csr_capacity;
   end

   always_comb begin
      if (cap_ff == '0) cap_eff = (SLOT_BITS+1)'(1);
      else if ({1'b0, cap_ff} > (CapBits+1)'(Slots)) cap_eff = (SLOT_BITS+1)'(Slots);
      else cap_eff = (SLOT_BITS+1)'(cap_ff);
   end

   assign full = !f_in_ready || clearing;

   hlis_front #(.SLOT_BITS(SLOT_BITS), .VALUE_BITS(VALUE_BITS), .GROUP_BITS(GROUP_BITS))
   u_front (
      .clock(clock), .reset(reset),
      .in_valid(push && !full), .in_ready(f_in_ready),
      .in_group(req_group), .in_qcode(req_query_code), .in_kcode(req_key_code),
      .in_value(req_key_value), .cap(cap_eff),
      .out_valid(f_valid), .out_ready(f_ready),
      .out_group(f_group), .out_qcode(f_q), .out_kcode(f_k), .out_value(f_v),
      .out_qslot(f_qs), .out_kslot(f_ks)
   );

   assign f_ready = !q_full;

   hlis_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .full(q_full), .wdata({f_group, f_q, f_k, f_v, f_qs, f_ks}),
      .pop(b_pop), .empty(q_empty), .rdata({b_group, b_q, b_k, b_v, b_qs, b_ks})
   );

   hlis_back #(.SLOT_BITS(SLOT_BITS), .VALUE_BITS(VALUE_BITS), .GROUP_BITS(GROUP_BITS))
   u_back (
      .clock(clock), .reset(reset),
      .in_valid(!q_empty), .in_pop(b_pop),
      .in_group(b_group), .in_qcode(b_q), .in_kcode(b_k), .in_value(b_v),
      .in_qslot(b_qs), .in_kslot(b_ks), .cap(cap_eff), .clearing(clearing),
      .res_valid(r_valid), .res_ready(pop),
      .res_hit(rsp_hit), .res_value(rsp_read_value),
      .res_claimed(rsp_claimed_new), .res_full(rsp_table_full)
   );

   assign empty = !r_valid;

`ifndef SYNTHESIS
   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_claimed_new && rsp_table_full))
      else $error("claimed and full together");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> rsp_read_value == '0)
      else $error("miss with nonzero value");
   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      cap_eff != '0 && cap_eff <= (SLOT_BITS+1)'(Slots))
      else $error("capacity out of range");
`endif
endmodule
`default_nettype wire

FILE: src/hlis_mul64.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlis_mul64
// Low 64 bits of a 64x64 product, one 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
module hlis_mul64 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      product
);
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [31:0] pa, pb;
   logic [63:0] pp_ff;
   logic        pp_vld_ff;
   logic [1:0]  pp_step_ff;

   always_comb begin
      unique case (step_ff)
         2'd0:    begin pa = a_ff[31:0];  pb = b_ff[31:0];  end
         2'd1:    begin pa = a_ff[63:32]; pb = b_ff[31:0];  end
         default: begin pa = a_ff[31:0];  pb = b_ff[63:32]; end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (pp_vld_ff) begin
         if (pp_step_ff == 2'd0) acc_in = pp_ff;
         else acc_in = acc_ff + {pp_ff[31:0], 32'd0};
      end
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
      end else if (busy_ff) begin
         if (step_ff == 2'd2) busy_in = 1'b0;
         else step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      pp_ff <= {32'd0, pa} * {32'd0, pb};
      pp_step_ff <= step_ff;
      acc_ff <= acc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         pp_vld_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         pp_vld_ff <= busy_ff && !start;
         done <= pp_vld_ff && pp_step_ff == 2'd2;
      end
   end

   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: src/hlis_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlis_front
// Accepts items and computes both home slots through a shared multiplier.
// ----------------------------------------------------------------------------
module hlis_front
   import hlis_pkg::*;
#(
   parameter int SLOT_BITS  = 10,
   parameter int VALUE_BITS = 64,
   parameter int GROUP_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [GROUP_BITS-1:0] in_group,
   input  wire logic [63:0]           in_qcode,
   input  wire logic [63:0]           in_kcode,
   input  wire logic [VALUE_BITS-1:0] in_value,
   input  wire logic [SLOT_BITS:0]    cap,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [GROUP_BITS-1:0]      out_group,
   output logic [63:0]                out_qcode,
   output logic [63:0]                out_kcode,
   output logic [VALUE_BITS-1:0]      out_value,
   output logic [SLOT_BITS-1:0]       out_qslot,
   output logic [SLOT_BITS-1:0]       out_kslot
);
   typedef enum logic [3:0] {
      S_IDLE, S_SALT, S_M1, S_M2, S_SC_HI, S_SC_LO, S_SCALE, S_DONE
   } state_type;

   state_type             state_ff;
   logic                  which_ff;
   logic [GROUP_BITS-1:0] group_ff;
   logic [63:0]           qcode_ff, kcode_ff, salt_ff, x_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [SLOT_BITS-1:0]  qslot_ff, kslot_ff;
   logic [63:0]           lo_ff, hi_ff;
   logic                  mul_start;
   logic [63:0]           mul_a, mul_b, mul_p;
   logic                  mul_done;
   logic [63:0]           mid;
   logic [SLOT_BITS-1:0]  slot;

   hlis_mul64 u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   // high half of h times capacity, from 32-bit halves
   assign mid  = hi_ff + {32'd0, lo_ff[63:32]};
   assign slot = mid[32 +: SLOT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mul_start <= 1'b0;
      end else begin
         mul_start <= (state_ff == S_IDLE && in_valid) ||
                      ((state_ff == S_SALT || state_ff == S_M1) && mul_done) ||
                      (state_ff == S_SCALE && !which_ff);
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               group_ff <= in_group;
               qcode_ff <= in_qcode;
               kcode_ff <= in_kcode;
               value_ff <= in_value;
               mul_a <= 64'(in_group);
               mul_b <= GoldenMul;
               which_ff <= 1'b0;
               state_ff <= S_SALT;
            end
            S_SALT: if (mul_done) begin
               salt_ff <= mul_p;
               x_ff <= (qcode_ff ^ mul_p) ^ ((qcode_ff ^ mul_p) >> 30);
               mul_a <= (qcode_ff ^ mul_p) ^ ((qcode_ff ^ mul_p) >> 30);
               mul_b <= MixMulA;
               state_ff <= S_M1;
            end
            S_M1: if (mul_done) begin
               mul_a <= mul_p ^ (mul_p >> 27);
               mul_b <= MixMulB;
               state_ff <= S_M2;
            end
            S_M2: if (mul_done) begin
               x_ff <= mul_p ^ (mul_p >> 31);
               state_ff <= S_SC_HI;
            end
            S_SC_HI: begin
               hi_ff <= {32'd0, x_ff[63:32]} * 64'(cap);
               lo_ff <= {32'd0, x_ff[31:0]} * 64'(cap);
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               if (!which_ff) begin
                  qslot_ff <= slot;
                  which_ff <= 1'b1;
                  mul_a <= (kcode_ff ^ salt_ff) ^ ((kcode_ff ^ salt_ff) >> 30);
                  mul_b <= MixMulA;
                  state_ff <= S_M1;
               end else begin
                  kslot_ff <= slot;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = state_ff == S_DONE;
   assign out_group = group_ff;
   assign out_qcode = qcode_ff;
   assign out_kcode = kcode_ff;
   assign out_value = value_ff;
   assign out_qslot = qslot_ff;
   assign out_kslot = kslot_ff;
endmodule
`default_nettype wire

FILE: src/hlis_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlis_queue
// Two-entry queue between the hash front and the probe back.
// ----------------------------------------------------------------------------
module hlis_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wdata;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wp_ff <= !wp_ff;
         if (do_pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule
`default_nettype wire

FILE: src/hlis_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlis_back
// Clears the slot memory after reset, then probes it: lookup walk, then insert walk, then result.
// ----------------------------------------------------------------------------
module hlis_back
   import hlis_pkg::*;
#(
   parameter int SLOT_BITS  = 10,
   parameter int VALUE_BITS = 64,
   parameter int GROUP_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_pop,
   input  wire logic [GROUP_BITS-1:0] in_group,
   input  wire logic [63:0]           in_qcode,
   input  wire logic [63:0]           in_kcode,
   input  wire logic [VALUE_BITS-1:0] in_value,
   input  wire logic [SLOT_BITS-1:0]  in_qslot,
   input  wire logic [SLOT_BITS-1:0]  in_kslot,
   input  wire logic [SLOT_BITS:0]    cap,
   output logic                       clearing,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output logic                       res_hit,
   output logic [VALUE_BITS-1:0]      res_value,
   output logic                       res_claimed,
   output logic                       res_full
);
   localparam int Slots = 1 << SLOT_BITS;
   localparam int EntBits = 1 + GROUP_BITS + 64 + VALUE_BITS;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_QRD, S_QCHK, S_KRD, S_KCHK, S_OUT
   } state_type;

   logic [EntBits-1:0]    mem [Slots];
   logic [EntBits-1:0]    rd_ff;
   state_type             state_ff;
   logic [SLOT_BITS-1:0]  addr_ff;
   logic [SLOT_BITS:0]    n_ff;
   logic [SLOT_BITS-1:0]  next_addr;
   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [EntBits-1:0]    wr_data;
   logic                  e_used;
   logic [GROUP_BITS-1:0] e_group;
   logic [63:0]           e_code;
   logic [VALUE_BITS-1:0] e_value;
   logic                  last_probe;

   assign {e_used, e_group, e_code, e_value} = rd_ff;
   assign next_addr  = ({1'b0, addr_ff} + 1'b1 == cap) ? '0 : addr_ff + 1'b1;
   assign last_probe = n_ff + 1'b1 == cap;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_KCHK) begin
         if (!e_used || (e_group == in_group && e_code == in_kcode)) begin
            wr_en = 1'b1;
            wr_data = {1'b1, in_group, in_kcode, in_value};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         in_pop <= 1'b0;
      end else begin
         in_pop <= state_ff == S_OUT && res_ready;
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (&addr_ff) state_ff <= S_IDLE;
            end
            S_IDLE: if (in_valid && !in_pop) begin
               addr_ff <= in_qslot;
               n_ff <= '0;
               res_hit <= 1'b0;
               res_value <= '0;
               state_ff <= S_QRD;
            end
            S_QRD: state_ff <= S_QCHK;
            S_QCHK: begin
               if (e_used && e_group == in_group && e_code == in_qcode) begin
                  res_hit <= 1'b1;
                  res_value <= e_value;
               end
               if (!e_used || (e_group == in_group && e_code == in_qcode) ||
                   last_probe) begin
                  addr_ff <= in_kslot;
                  n_ff <= '0;
                  state_ff <= S_KRD;
               end else begin
                  addr_ff <= next_addr;
                  n_ff <= n_ff + 1'b1;
                  state_ff <= S_QRD;
               end
            end
            S_KRD: state_ff <= S_KCHK;
            S_KCHK: begin
               if (wr_en) begin
                  res_claimed <= !e_used;
                  res_full <= 1'b0;
                  state_ff <= S_OUT;
               end else if (last_probe) begin
                  res_claimed <= 1'b0;
                  res_full <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  addr_ff <= next_addr;
                  n_ff <= n_ff + 1'b1;
                  state_ff <= S_KRD;
               end
            end
            S_OUT: if (res_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign clearing  = state_ff == S_CLEAR;
   assign res_valid = state_ff == S_OUT;
endmodule
`default_nettype wire

FILE: tb/hashed_lookup_then_insert_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_lookup_then_insert_store_tb
// Drives (group, query, key, value) items into the hash store, tracks the
// expected table contents in a local copy and checks every lookup and insert
// outcome. Capacity is swept over several settings, including the extremes.
// ----------------------------------------------------------------------------
module hashed_lookup_then_insert_store_tb
   import hlis_pkg::*;
();

   localparam int NumSlots = 1024;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic [15:0] group;
      logic [63:0] query_code;
      logic [63:0] key_code;
      logic [63:0] key_value;
   } store_req_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] read_value;
      logic        claimed_new;
      logic        table_full;
   } store_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [15:0] req_group = '0;
   logic [63:0] req_query_code = '0, req_key_code = '0, req_key_value = '0;
   logic rsp_hit, rsp_claimed_new, rsp_table_full;
   logic [63:0] rsp_read_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CapBits-1:0] csr_capacity = '0;

   hashed_lookup_then_insert_store u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_group(req_group), .req_query_code(req_query_code),
      .req_key_code(req_key_code), .req_key_value(req_key_value),
      .empty(empty), .pop(pop), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_claimed_new(rsp_claimed_new), .rsp_table_full(rsp_table_full),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_capacity(csr_capacity)
   );

   always #10 clock = ~clock;

   // shadow of the table
   logic        shadow_used[NumSlots];
   logic [15:0] shadow_group[NumSlots];
   logic [63:0] shadow_code[NumSlots];
   logic [63:0] shadow_value[NumSlots];
   logic [CapBits-1:0] shadow_capacity;

   store_req_type pending_items[$];
   store_rsp_type expected_rsps[$];
   store_req_type recent_keys[$];
   int  send_idle_pct = 24;
   int  recv_idle_pct = 81;
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  cfg_pending = 1'b0;
   logic [CapBits-1:0] cfg_value;

   function automatic logic [63:0] mix_code(logic [63:0] code, logic [15:0] grp);
      logic [63:0] x;
      x = code ^ (64'(grp) * GoldenMul);
      x = x ^ (x >> 30);
      x = x * MixMulA;
      x = x ^ (x >> 27);
      x = x * MixMulB;
      x = x ^ (x >> 31);
      return x;
   endfunction

   function automatic int home_slot(logic [63:0] code, logic [15:0] grp, int cap);
      logic [127:0] prod;
      prod = 128'(mix_code(code, grp)) * 128'(cap);
      return int'(prod[127:64]) % cap;
   endfunction

   function automatic store_rsp_type predict_store(store_req_type it);
      store_rsp_type r;
      int cap, s;
      cap = (shadow_capacity == 0) ? 1 :
            (shadow_capacity > NumSlots) ? NumSlots : int'(shadow_capacity);
      r = '0;
      r.table_full = 1'b1;
      s = home_slot(it.query_code, it.group, cap);
      for (int n = 0; n < cap; n++) begin
         if (!shadow_used[s]) break;
         if (shadow_group[s] == it.group && shadow_code[s] == it.query_code) begin
            r.hit = 1'b1;
            r.read_value = shadow_value[s];
            break;
         end
         s = (s + 1 == cap) ? 0 : s + 1;
      end
      s = home_slot(it.key_code, it.group, cap);
      for (int n = 0; n < cap; n++) begin
         if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_group[s] = it.group;
            shadow_code[s] = it.key_code;
            shadow_value[s] = it.key_value;
            r.claimed_new = 1'b1;
            r.table_full = 1'b0;
            break;
         end
         if (shadow_group[s] == it.group && shadow_code[s] == it.key_code) begin
            shadow_value[s] = it.key_value;
            r.table_full = 1'b0;
            break;
         end
         s = (s + 1 == cap) ? 0 : s + 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // item often reuses earlier keys so lookups hit and inserts overwrite
   function automatic store_req_type make_item(int ngroups, int ncodes);
      store_req_type it;
      it.group = 16'($urandom_range(0, ngroups - 1));
      it.query_code = 64'($urandom_range(0, ncodes - 1));
      it.key_code = 64'($urandom_range(0, ncodes - 1));
      it.key_value = rand64();
      case ($urandom_range(0, 9))
         0: it.group = 16'($urandom());
         1: it.query_code = rand64();
         2: it.key_code = rand64();
         3: if (recent_keys.size() > 0) begin
               it.group = recent_keys[$urandom_range(0, recent_keys.size() - 1)].group;
            end
         default: ;
      endcase
      if (recent_keys.size() > 0 && $urandom_range(0, 2) == 0) begin
         store_req_type old;
         old = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
         it.group = old.group;
         it.query_code = old.key_code;
      end
      recent_keys.push_back(it);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_rsps.push_back(predict_store({req_group, req_query_code,
                                                   req_key_code, req_key_value}));
         end
         if (!push || !full) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               store_req_type it;
               it = pending_items.pop_front();
               push <= 1'b1;
               req_group <= it.group;
               req_query_code <= it.query_code;
               req_key_code <= it.key_code;
               req_key_value <= it.key_value;
            end else begin
               push <= 1'b0;
            end
         end
         if (csr_valid && csr_ready) begin
            shadow_capacity = csr_capacity;
            csr_valid <= 1'b0;
            cfg_pending = 1'b0;
         end else if (cfg_pending && !csr_valid) begin
            csr_valid <= 1'b1;
            csr_capacity <= cfg_value;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            store_rsp_type got, want;
            got = {rsp_hit, rsp_read_value, rsp_claimed_new, rsp_table_full};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // sampled away from the driving edge so the queues and push have settled
   task automatic drain();
      while (pending_items.size() > 0 || push || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_capacity(logic [CapBits-1:0] cap);
      cfg_value = cap;
      cfg_pending = 1'b1;
      while (cfg_pending) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      store_req_type it;
      for (int i = 0; i < NumSlots; i++) shadow_used[i] = 1'b0;
      shadow_capacity = CapBits'(NumSlots);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // clearing pass: full stays high, driver waits on it

      // directed: extremes of fields, hit, overwrite, full table
      pending_items.push_back('{16'h0000, 64'h0, 64'h0, 64'h0});
      pending_items.push_back('{16'h0000, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
      pending_items.push_back('{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 64'hA5A5_5A5A_0F0F_F0F0});
      pending_items.push_back('{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h1});
      pending_items.push_back('{16'h0001, 64'h0, 64'h0, 64'h5});
      pending_items.push_back('{16'h0000, 64'h0, 64'h1234, 64'h6});
      drain();
      // capacity 1: fill then full table; capacity 0 acts as 1
      set_capacity(1);
      pending_items.push_back('{16'h0007, 64'h1, 64'h2, 64'h11});
      pending_items.push_back('{16'h0007, 64'h2, 64'h3, 64'h22});
      pending_items.push_back('{16'h0007, 64'h2, 64'h2, 64'h33});
      pending_items.push_back('{16'h0007, 64'h3, 64'h9, 64'h44});
      drain();
      set_capacity(0);
      pending_items.push_back('{16'h0007, 64'h2, 64'h5, 64'h55});
      drain();
      // above the slot count acts as full size; entries above capacity reappear
      set_capacity(11'h7FF);
      pending_items.push_back('{16'h0000, 64'h1234, 64'h0, 64'h66});
      pending_items.push_back('{16'hFFFF, 64'h0, 64'h77, 64'h77});
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         int cap;
         case (ph)
            0: cap = 2;
            1: cap = 1024;
            2: cap = $urandom_range(3, 40);
            3: cap = 1;
            4: cap = $urandom_range(41, 1023);
            default: cap = 1024;
         endcase
         if (ph == 2) begin send_idle_pct = 81; recv_idle_pct = 24; end
         if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
         set_capacity(CapBits'(cap));
         for (int i = 0; i < 220; i++) begin
            it = make_item(cap < 8 ? 2 : 4, cap < 8 ? 4 : 3 * cap);
            pending_items.push_back(it);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
